// File: rtl/core/complex_arithmetic_unit_defines.svh
// Assertion macros shared by the complex arithmetic unit RTL.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Immediate implication checked on every clock edge outside reset.
`define CAU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked a fixed number of cycles later.
`define CAU_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int PART_WIDTH_DEF = 16;
  localparam int CMD_W          = 4;
  localparam int RES_W          = 33;
  localparam int EXT_W          = 65;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_NEG = 4'd4,
    CMD_EQ  = 4'd5,
    CMD_NE  = 4'd6,
    CMD_LE  = 4'd7,
    CMD_GE  = 4'd8,
    CMD_LT  = 4'd9,
    CMD_GT  = 4'd10
  } cmd_t;

  // Result of everything except a real quotient.
  typedef struct packed {
    logic [RES_W-1:0] re;
    logic [RES_W-1:0] im;
    logic             cmp;
    logic             st;
  } side_t;

  // Control that travels with a beat down the divider chain.
  typedef struct packed {
    logic valid;
    logic use_div;
    logic neg_re;
    logic neg_im;
  } ctrl_t;

endpackage
`default_nettype wire

// File: rtl/core/cau_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division cell: retires one quotient bit per lane per cycle.
// ----------------------------------------------------------------------------
module cau_div_cell
  import cau_pkg::*;
#(
  parameter int NW = 33,
  parameter int DW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ctrl_t                 ctrl_in,
  input  wire side_t                 side_in,
  input  wire logic [DW-1:0]         den_in,
  input  wire logic [1:0][DW-1:0]    rem_in,
  input  wire logic [1:0][NW-1:0]    nq_in,
  output ctrl_t                      ctrl_out,
  output side_t                      side_out,
  output logic [DW-1:0]              den_out,
  output logic [1:0][DW-1:0]         rem_out,
  output logic [1:0][NW-1:0]         nq_out
);

  logic [1:0][DW+1:0] diff;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l] = {1'b0, rem_in[l], nq_in[l][NW-1]} - {2'b00, den_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.use_div <= ctrl_in.use_div;
    ctrl_out.neg_re  <= ctrl_in.neg_re;
    ctrl_out.neg_im  <= ctrl_in.neg_im;
    side_out         <= side_in;
    den_out          <= den_in;
    for (int l = 0; l < 2; l++) begin
      // keep the difference when no borrow, shift the quotient bit in
      if (!diff[l][DW+1]) begin
        rem_out[l] <= diff[l][DW-1:0];
        nq_out[l]  <= {nq_in[l][NW-2:0], 1'b1};
      end else begin
        rem_out[l] <= {rem_in[l][DW-2:0], nq_in[l][NW-1]};
        nq_out[l]  <= {nq_in[l][NW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/complex_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add/sub/mul/div/negate and part-wise comparisons.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd, a_re, a_im, b_re, b_im and raise start; the beat is taken at
//   any rising edge where start is high and busy is low. busy is high only
//   while rst is held (and the cycle after), so one beat per cycle is taken.
//   Each beat yields exactly one result beat on res_re, res_im, cmp_true and
//   status, marked by done for one cycle. The receiver cannot stall, so the
//   result is simply presented once and then replaced.
// Sizing: NW = 2*PART_WIDTH+1 (capped at 64); throughput is one beat per
//   cycle for every command.
// Structure: input register, product stage (six multipliers), sum stage,
//   magnitude stage, then a chain of NW division cells that each retire one
//   quotient bit of both parts, and a sign/select output register. The
//   divider chain length sets the latency; every command travels it so
//   results stay in order.
// Reset: clears all valid bits; no result is shown until new beats arrive.
// Division by zero gives status 1 and returns the left operand unchanged.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_defines.svh"
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int PART_WIDTH = PART_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [CMD_W-1:0]             cmd,
  input  wire logic signed [PART_WIDTH-1:0] a_re,
  input  wire logic signed [PART_WIDTH-1:0] a_im,
  input  wire logic signed [PART_WIDTH-1:0] b_re,
  input  wire logic signed [PART_WIDTH-1:0] b_im,
  output logic                              done,
  output logic signed [RES_W-1:0]           res_re,
  output logic signed [RES_W-1:0]           res_im,
  output logic                              cmp_true,
  output logic                              status
);

  localparam int PW  = PART_WIDTH;
  localparam int PPW = 2 * PW;
  localparam int NSW = 2 * PW + 1;
  localparam int NW  = (NSW > 64) ? 64 : NSW;
  localparam int DW  = PPW;
  localparam int LAT = NW + 5;

  // Stage 1: hold the accepted beat
  logic                 s1_v;
  logic [CMD_W-1:0]     s1_cmd;
  logic signed [PW-1:0] s1_ar, s1_ai, s1_br, s1_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      busy <= 1'b1;
    end else begin
      s1_v <= start && !busy;
      busy <= 1'b0;
    end
    s1_cmd <= cmd;
    s1_ar  <= a_re;
    s1_ai  <= a_im;
    s1_br  <= b_re;
    s1_bi  <= b_im;
  end

  // Stage 2: products plus the cheap results
  logic signed [EXT_W-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [EXT_W-1:0] add_re, add_im, sub_re, sub_im, neg_re, neg_im;
  side_t                   side_s1;
  logic                    eq_re, eq_im, le_re, le_im, lt_re, lt_im;

  assign ar_x = EXT_W'(s1_ar);
  assign ai_x = EXT_W'(s1_ai);
  assign br_x = EXT_W'(s1_br);
  assign bi_x = EXT_W'(s1_bi);
  assign add_re = ar_x + br_x;
  assign add_im = ai_x + bi_x;
  assign sub_re = ar_x - br_x;
  assign sub_im = ai_x - bi_x;
  assign neg_re = -ar_x;
  assign neg_im = -ai_x;
  assign eq_re = (s1_ar == s1_br);
  assign eq_im = (s1_ai == s1_bi);
  assign le_re = (s1_ar <= s1_br);
  assign le_im = (s1_ai <= s1_bi);
  assign lt_re = (s1_ar < s1_br);
  assign lt_im = (s1_ai < s1_bi);

  always_comb begin
    side_s1 = '0;
    case (cmd_t'(s1_cmd))
      CMD_ADD: begin
        side_s1.re = add_re[RES_W-1:0];
        side_s1.im = add_im[RES_W-1:0];
      end
      CMD_SUB: begin
        side_s1.re = sub_re[RES_W-1:0];
        side_s1.im = sub_im[RES_W-1:0];
      end
      CMD_NEG: begin
        side_s1.re = neg_re[RES_W-1:0];
        side_s1.im = neg_im[RES_W-1:0];
      end
      CMD_DIV: begin
        // divide-by-zero answer; dropped later when the divisor is nonzero
        side_s1.re = ar_x[RES_W-1:0];
        side_s1.im = ai_x[RES_W-1:0];
        side_s1.st = 1'b1;
      end
      CMD_EQ:  side_s1.cmp = eq_re && eq_im;
      CMD_NE:  side_s1.cmp = !(eq_re && eq_im);
      CMD_LE:  side_s1.cmp = le_re && le_im;
      CMD_GE:  side_s1.cmp = !lt_re && !lt_im;
      CMD_LT:  side_s1.cmp = lt_re && lt_im;
      CMD_GT:  side_s1.cmp = !le_re && !le_im;
      default: side_s1 = '0;
    endcase
  end

  logic                  s2_v, s2_mul, s2_div;
  side_t                 s2_side;
  logic signed [PPW-1:0] p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_mul  <= (cmd_t'(s1_cmd) == CMD_MUL);
    s2_div  <= (cmd_t'(s1_cmd) == CMD_DIV);
    s2_side <= side_s1;
    p_rr    <= s1_ar * s1_br;
    p_ii    <= s1_ai * s1_bi;
    p_ri    <= s1_ar * s1_bi;
    p_ir    <= s1_ai * s1_br;
    p_br2   <= s1_br * s1_br;
    p_bi2   <= s1_bi * s1_bi;
  end

  // Stage 3: product sums, numerators and the divisor
  logic signed [EXT_W-1:0] mul_re, mul_im;
  logic signed [NSW-1:0]   nre_full, nim_full;
  logic [DW-1:0]           den_c;
  side_t                   side_s2;

  assign mul_re   = EXT_W'(p_rr) - EXT_W'(p_ii);
  assign mul_im   = EXT_W'(p_ri) + EXT_W'(p_ir);
  assign nre_full = NSW'(p_rr) + NSW'(p_ii);
  assign nim_full = NSW'(p_ir) - NSW'(p_ri);
  assign den_c    = $unsigned(p_br2) + $unsigned(p_bi2);

  always_comb begin
    side_s2 = s2_side;
    if (s2_mul) begin
      side_s2.re = mul_re[RES_W-1:0];
      side_s2.im = mul_im[RES_W-1:0];
    end
  end

  logic                 s3_v, s3_div;
  side_t                s3_side;
  logic signed [NW-1:0] s3_nre, s3_nim;
  logic [DW-1:0]        s3_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_div  <= s2_div && (den_c != '0);
    s3_side <= side_s2;
    s3_nre  <= nre_full[NW-1:0];
    s3_nim  <= nim_full[NW-1:0];
    s3_den  <= den_c;
  end

  // Stage 4: magnitudes into the head of the divider chain
  ctrl_t                  c_ctrl [0:NW];
  side_t                  c_side [0:NW];
  logic [DW-1:0]          c_den  [0:NW];
  logic [1:0][DW-1:0]     c_rem  [0:NW];
  logic [1:0][NW-1:0]     c_nq   [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_ctrl[0].valid <= 1'b0;
    end else begin
      c_ctrl[0].valid <= s3_v;
    end
    c_ctrl[0].use_div <= s3_div;
    c_ctrl[0].neg_re  <= s3_nre[NW-1];
    c_ctrl[0].neg_im  <= s3_nim[NW-1];
    c_side[0]         <= s3_side;
    c_den[0]          <= s3_den;
    c_rem[0]          <= '0;
    c_nq[0][0]        <= s3_nre[NW-1] ? -s3_nre : s3_nre;
    c_nq[0][1]        <= s3_nim[NW-1] ? -s3_nim : s3_nim;
  end

  // Divider chain: one quotient bit per cell, MSB first
  for (genvar k = 0; k < NW; k++) begin : g_cell
    cau_div_cell #(
      .NW (NW),
      .DW (DW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (c_ctrl[k]),
      .side_in  (c_side[k]),
      .den_in   (c_den[k]),
      .rem_in   (c_rem[k]),
      .nq_in    (c_nq[k]),
      .ctrl_out (c_ctrl[k+1]),
      .side_out (c_side[k+1]),
      .den_out  (c_den[k+1]),
      .rem_out  (c_rem[k+1]),
      .nq_out   (c_nq[k+1])
    );
  end

  // Output stage: apply signs to the quotient and pick the result
  logic [EXT_W-1:0] q_re, q_im, qs_re, qs_im;
  ctrl_t            t_ctrl;
  side_t            t_side;

  assign t_ctrl = c_ctrl[NW];
  assign t_side = c_side[NW];
  assign q_re   = EXT_W'(c_nq[NW][0]);
  assign q_im   = EXT_W'(c_nq[NW][1]);
  assign qs_re  = t_ctrl.neg_re ? -q_re : q_re;
  assign qs_im  = t_ctrl.neg_im ? -q_im : q_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_ctrl.valid;
    end
    if (t_ctrl.use_div) begin
      res_re   <= qs_re[RES_W-1:0];
      res_im   <= qs_im[RES_W-1:0];
      cmp_true <= 1'b0;
      status   <= 1'b0;
    end else begin
      res_re   <= t_side.re;
      res_im   <= t_side.im;
      cmp_true <= t_side.cmp;
      status   <= t_side.st;
    end
  end

  `CAU_ASSERT_DELAY(a_lat, start && !busy, LAT, done, "accepted beat did not come out on time")
  `CAU_ASSERT_IMPL(a_excl, done, !(cmp_true && status), "comparison and divide fault together")
  `CAU_ASSERT_IMPL(a_cmpz, done && cmp_true, res_re == '0 && res_im == '0, "comparison with data")

endmodule
`default_nettype wire
